@@ rtl/arp_cache_with_request_retry_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_MACROS_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ARP_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the condition.
`define ARP_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

@@ rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the ARP cache cells and the top level.
// ----------------------------------------------------------------------------
package arpc_pkg;
    localparam int CacheDepth   = 16;
    localparam int PendingDepth = 8;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_QUEUE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_QUEUE  = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_SEND   = 3'd4;
    localparam logic [2:0] KIND_GIVEUP = 3'd5;
    localparam logic [2:0] KIND_DONE   = 3'd6;

    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic        hit;
        logic [47:0] mac_out;
        logic [31:0] ip_out;
        logic [3:0]  sent_count;
        logic        status;
        logic        last;
    } t_rsp;

    // Command broadcast to every cell of a row.
    typedef struct packed {
        logic        upd_en;    // write at the selected cell
        logic        tick;      // age every cell
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cmd;

    // Scan token handed from cell to cell: an earlier cell is already free.
    typedef struct packed {
        logic free_seen;
    } t_chain;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_OUT
    } t_state;
endpackage

@@ rtl/arpc_cache_cell.sv @@
// ----------------------------------------------------------------------------
// arpc_cache_cell
// One cache entry: address, hardware address, age, valid bit.
// ----------------------------------------------------------------------------
module arpc_cache_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_cmd      i_cmd,
    input  logic                i_any_hit,
    input  logic [15:0]         i_timeout,
    input  arpc_pkg::t_chain    i_chain,
    output arpc_pkg::t_chain    o_chain,
    output logic                o_hit,
    output logic [47:0]         o_mac
);
    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [15:0] r_age;
    logic        w_match;
    logic        w_sel;
    logic [15:0] n_age;

    assign w_match = r_valid && (r_ip == i_cmd.ip);
    // Written where the address hits, or at the first free cell when no cell hits.
    assign w_sel = w_match || (!i_any_hit && !r_valid && !i_chain.free_seen);
    assign o_chain.free_seen = i_chain.free_seen || !r_valid;
    assign o_hit = w_match;
    assign o_mac = w_match ? r_mac : 48'd0;
    assign n_age = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.tick) begin
            if (r_valid && n_age >= i_timeout) begin
                r_valid <= 1'b0;
            end
        end else if (i_cmd.upd_en && w_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_age <= n_age;
        end else if (i_cmd.upd_en && w_sel) begin
            r_ip  <= i_cmd.ip;
            r_mac <= i_cmd.mac;
            r_age <= 16'd0;
        end
    end
endmodule

@@ rtl/arpc_pend_cell.sv @@
// ----------------------------------------------------------------------------
// arpc_pend_cell
// One pending request: address, ticks since last send, send count.
// ----------------------------------------------------------------------------
module arpc_pend_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_cmd      i_cmd,
    input  logic                i_any_hit,
    input  logic                i_remove,
    input  logic                i_serve,
    input  logic [3:0]          i_limit,
    input  logic [7:0]          i_interval,
    input  arpc_pkg::t_chain    i_chain,
    output arpc_pkg::t_chain    o_chain,
    output logic                o_hit,
    output logic                o_due,
    output logic                o_giveup,
    output logic [31:0]         o_ip,
    output logic [3:0]          o_sent
);
    logic        r_valid;
    logic        r_due;
    logic [31:0] r_ip;
    logic [7:0]  r_elapsed;
    logic [3:0]  r_sent;
    logic        w_match;
    logic        w_claim;
    logic [7:0]  n_elapsed;

    assign w_match = r_valid && (r_ip == i_cmd.ip);
    assign w_claim = !r_valid && !i_chain.free_seen && !i_any_hit;
    assign o_chain.free_seen = i_chain.free_seen || !r_valid;
    assign o_hit = w_match;
    assign n_elapsed = (r_elapsed == 8'hFF) ? r_elapsed : r_elapsed + 8'd1;
    assign o_due = r_due;
    assign o_giveup = r_sent >= i_limit;
    assign o_ip = r_ip;
    assign o_sent = o_giveup ? r_sent : r_sent + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_due   <= 1'b0;
        end else if (i_cmd.tick) begin
            r_due <= r_valid && (n_elapsed >= i_interval);
        end else if (i_serve) begin
            r_due <= 1'b0;
            if (o_giveup) begin
                r_valid <= 1'b0;
            end
        end else if (i_remove && w_match) begin
            r_valid <= 1'b0;
        end else if (i_cmd.upd_en && w_claim) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_elapsed <= n_elapsed;
        end else if (i_serve) begin
            r_elapsed <= 8'd0;
            r_sent    <= o_sent;
        end else if (i_cmd.upd_en && w_claim) begin
            r_ip      <= i_cmd.ip;
            r_elapsed <= 8'hFF;
            r_sent    <= 4'd0;
        end
    end
endmodule

@@ rtl/arp_cache_with_request_retry.sv @@
// A request is accepted only when the block is idle with its result register
// empty. For a lookup, insert, queue or remove request, the execute state
// compares against every cell of both rows, updates them and registers the
// result; the output state then presents the result and returns the block to
// idle once it is taken. A tick ages every cell, then serves each due pending
// request in slot order, registering and then presenting its send or give-up
// result, and ends with a done result. A result that the receiver stalls stays
// presented, and the block waits, until it is taken.
// ----------------------------------------------------------------------------
// arp_cache_with_request_retry
// ARP cache with per-entry ageing and a pending-request table with retries.
// ----------------------------------------------------------------------------
`include "arp_cache_with_request_retry_macros.svh"
module arp_cache_with_request_retry (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  arpc_pkg::t_req    i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output arpc_pkg::t_rsp    o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    localparam int CD = arpc_pkg::CacheDepth;
    localparam int PD = arpc_pkg::PendingDepth;

    arpc_pkg::t_state r_state, n_state;
    arpc_pkg::t_req   r_req;
    arpc_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_ovalid, n_ovalid;
    logic [15:0]      r_timeout;
    logic [3:0]       r_limit;
    logic [7:0]       r_interval;

    arpc_pkg::t_cmd   w_ccmd, w_pcmd;
    arpc_pkg::t_chain w_cch [CD+1];
    arpc_pkg::t_chain w_pch [PD+1];
    logic [CD-1:0]    w_chit;
    logic [47:0]      w_cmac [CD];
    logic [47:0]      w_mac_or [CD+1];
    logic [PD-1:0]    w_phit, w_pdue, w_pgive, w_serve, w_first;
    logic [31:0]      w_pip [PD];
    logic [3:0]       w_psent [PD];
    logic [31:0]      w_sip [PD+1];
    logic [3:0]       w_ssent [PD+1];
    logic             w_sgive [PD+1];
    logic             w_remove, w_accept, w_exec;
    logic             w_cany, w_pany;

    assign o_cfg_ready = (r_state == arpc_pkg::ST_IDLE) && !r_ovalid;
    assign o_stall = !((r_state == arpc_pkg::ST_IDLE) && !r_ovalid);
    assign w_accept = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data = r_rsp;
    assign w_exec = r_state == arpc_pkg::ST_EXEC;
    assign w_cany = |w_chit;
    assign w_pany = |w_phit;

    assign w_ccmd.upd_en   = w_exec && (r_req.op == arpc_pkg::OP_INSERT);
    assign w_ccmd.tick     = w_exec && (r_req.op == arpc_pkg::OP_TICK);
    assign w_ccmd.ip       = r_req.ip_addr;
    assign w_ccmd.mac      = r_req.mac_addr;
    assign w_pcmd.upd_en   = w_exec && (r_req.op == arpc_pkg::OP_QUEUE);
    assign w_pcmd.tick     = w_exec && (r_req.op == arpc_pkg::OP_TICK);
    assign w_pcmd.ip       = r_req.ip_addr;
    assign w_pcmd.mac      = r_req.mac_addr;
    assign w_remove = w_exec && (r_req.op == arpc_pkg::OP_REMOVE);

    assign w_cch[0] = '0;
    assign w_mac_or[0] = '0;
    for (genvar g = 0; g < CD; g++) begin : g_cache
        arpc_cache_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_ccmd), .i_any_hit(w_cany),
            .i_timeout(r_timeout), .i_chain(w_cch[g]), .o_chain(w_cch[g+1]),
            .o_hit(w_chit[g]), .o_mac(w_cmac[g])
        );
        assign w_mac_or[g+1] = w_mac_or[g] | w_cmac[g];
    end

    // Serve the lowest due request: a one-hot pick along the row.
    assign w_pch[0] = '0;
    assign w_sip[0] = '0;
    assign w_ssent[0] = '0;
    assign w_sgive[0] = 1'b0;
    for (genvar g = 0; g < PD; g++) begin : g_pend
        logic w_before;
        if (g == 0) begin : g_z
            assign w_before = 1'b0;
        end else begin : g_nz
            assign w_before = |w_pdue[g-1:0];
        end
        assign w_first[g] = w_pdue[g] && !w_before;
        assign w_serve[g] = w_first[g] && (r_state == arpc_pkg::ST_SCAN) && !r_ovalid;
        arpc_pend_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_pcmd), .i_any_hit(w_pany),
            .i_remove(w_remove), .i_serve(w_serve[g]), .i_limit(r_limit),
            .i_interval(r_interval), .i_chain(w_pch[g]), .o_chain(w_pch[g+1]),
            .o_hit(w_phit[g]), .o_due(w_pdue[g]), .o_giveup(w_pgive[g]),
            .o_ip(w_pip[g]), .o_sent(w_psent[g])
        );
        assign w_sip[g+1]   = w_sip[g] | (w_first[g] ? w_pip[g] : 32'd0);
        assign w_ssent[g+1] = w_ssent[g] | (w_first[g] ? w_psent[g] : 4'd0);
        assign w_sgive[g+1] = w_sgive[g] | (w_first[g] && w_pgive[g]);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (w_accept && i_data.op <= arpc_pkg::OP_TICK) begin
                    n_state = arpc_pkg::ST_EXEC;
                end
            end
            arpc_pkg::ST_EXEC: begin
                n_state = (r_req.op == arpc_pkg::OP_TICK) ? arpc_pkg::ST_SCAN
                                                          : arpc_pkg::ST_OUT;
            end
            arpc_pkg::ST_SCAN: begin
                if (!r_ovalid && !(|w_pdue)) begin
                    n_state = arpc_pkg::ST_OUT;
                end
            end
            arpc_pkg::ST_OUT: begin
                if (!r_ovalid) begin
                    n_state = arpc_pkg::ST_IDLE;
                end
            end
            default: n_state = arpc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_rsp = r_rsp;
        n_ovalid = r_ovalid && i_stall;
        if (w_exec) begin
            n_rsp = '0;
            n_rsp.last = 1'b1;
            unique case (r_req.op)
                arpc_pkg::OP_LOOKUP: begin
                    n_rsp.kind = arpc_pkg::KIND_LOOKUP;
                    n_rsp.hit = w_cany;
                    n_rsp.mac_out = w_mac_or[CD];
                    n_ovalid = 1'b1;
                end
                arpc_pkg::OP_INSERT: begin
                    n_rsp.kind = arpc_pkg::KIND_INSERT;
                    n_rsp.hit = w_pany;
                    n_rsp.status = !w_cany && !w_cch[CD].free_seen;
                    n_ovalid = 1'b1;
                end
                arpc_pkg::OP_QUEUE: begin
                    n_rsp.kind = arpc_pkg::KIND_QUEUE;
                    n_rsp.hit = w_pany;
                    n_rsp.status = !w_pany && !w_pch[PD].free_seen;
                    n_ovalid = 1'b1;
                end
                arpc_pkg::OP_REMOVE: begin
                    n_rsp.kind = arpc_pkg::KIND_REMOVE;
                    n_rsp.hit = w_pany;
                    n_ovalid = 1'b1;
                end
                default: begin
                    n_ovalid = 1'b0;
                end
            endcase
        end else if (r_state == arpc_pkg::ST_SCAN && !r_ovalid) begin
            n_rsp = '0;
            if (|w_pdue) begin
                n_rsp.kind = w_sgive[PD] ? arpc_pkg::KIND_GIVEUP : arpc_pkg::KIND_SEND;
                n_rsp.ip_out = w_sip[PD];
                n_rsp.sent_count = w_ssent[PD];
            end else begin
                n_rsp.kind = arpc_pkg::KIND_DONE;
                n_rsp.last = 1'b1;
            end
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpc_pkg::ST_IDLE;
            r_ovalid   <= 1'b0;
            r_timeout  <= 16'd30;
            r_limit    <= 4'd5;
            r_interval <= 8'd1;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    arpc_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    arpc_pkg::REG_LIMIT:    r_limit    <= i_cfg_data[3:0];
                    arpc_pkg::REG_INTERVAL: r_interval <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (w_accept) begin
            r_req <= i_data;
        end
    end

    `ARP_ASSERT_IMP(a_one_serve, i_clk, i_rst_n, 1'b1, $onehot0(w_serve))
    `ARP_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != arpc_pkg::ST_IDLE, o_stall)
    `ARP_ASSERT_NEXT(a_exec_out, i_clk, i_rst_n,
        w_exec && r_req.op != arpc_pkg::OP_TICK, o_valid && o_data.last)
endmodule
